@@ rtl/adrc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package adrc_pkg;
    localparam int DataW = 32;
    localparam int GainW = 31;
    localparam int RegIdxW = 3;
    localparam int CntW = 7;

    typedef enum logic [RegIdxW-1:0] {
        REG_STEP_SIZE  = 3'd0,
        REG_PLANT_GAIN = 3'd1,
        REG_BETA_ONE   = 3'd2,
        REG_BETA_TWO   = 3'd3,
        REG_K_ONE      = 3'd4,
        REG_DRIVE_MIN  = 3'd5,
        REG_DRIVE_MAX  = 3'd6
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_MUL_B1,
        ST_MUL_B0,
        ST_MUL_B2,
        ST_MUL_H1,
        ST_MUL_H2,
        ST_ERR2,
        ST_MUL_K1,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_unit_ctl;

    function automatic logic signed [DataW-1:0] sat32(input logic signed [65:0] v);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'sd2147483647;
        lo = -66'sd2147483648;
        if (v > hi) begin
            sat32 = 32'sh7fffffff;
        end else if (v < lo) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = v[DataW-1:0];
        end
    endfunction
endpackage
`default_nettype wire

@@ rtl/adrc_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface adrc_in_if;
    logic valid;
    logic ready;
    logic signed [31:0] reference;
    logic signed [31:0] measured;
    modport source (output valid, output reference, output measured, input ready);
    modport sink (input valid, input reference, input measured, output ready);
endinterface

interface adrc_out_if;
    logic valid;
    logic ready;
    logic signed [31:0] drive;
    modport source (output valid, output drive, input ready);
    modport sink (input valid, input drive, output ready);
endinterface
`default_nettype wire

@@ rtl/adrc_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Bit-serial signed multiplier: a 33-bit signed multiplicand times a 33-bit
// signed multiplier, one multiplier bit per cycle (shift and add).
module adrc_mul
    import adrc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [32:0] i_a,
    input  wire logic signed [32:0] i_b,
    output t_unit_ctl               o_ctl,
    output logic signed [65:0]      o_prod
);
    logic signed [65:0] r_acc, n_acc;
    logic        [32:0] r_b, n_b;
    logic signed [32:0] r_a, n_a;
    logic   [CntW-1:0]  r_cnt, n_cnt;
    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic signed [65:0] w_addend;

    always_comb begin
        w_addend = {{33{r_a[32]}}, r_a} <<< r_cnt[5:0];
        n_acc = r_acc;
        n_b = r_b;
        n_a = r_a;
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_acc = '0;
            n_a = i_a;
            n_b = i_b;
            n_cnt = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_b[0]) begin
                // The top bit of a two's complement multiplier weighs negative.
                n_acc = (r_cnt == CntW'(32)) ? r_acc - w_addend : r_acc + w_addend;
            end
            n_b = r_b >> 1;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CntW'(32)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_b <= n_b;
        r_a <= n_a;
        r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_ctl = '{start: i_start, busy: r_busy, done: r_done};
    assign o_prod = r_acc;

    ap_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("multiplier done without work");
    ap_not_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_done && r_busy && !$past(i_start))) else $error("done while busy");
    ap_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt <= CntW'(32)) else $error("multiplier count overrun");
endmodule
`default_nettype wire

@@ rtl/adrc_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider on magnitudes, one quotient bit per cycle: 48-bit
// dividend by a 31-bit divisor, quotient truncated toward zero.
module adrc_div
    import adrc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic signed [31:0] i_num,
    input  wire logic [GainW-1:0]  i_den,
    output t_unit_ctl              o_ctl,
    output logic signed [65:0]     o_quot
);
    logic [47:0]       r_q, n_q;
    logic [31:0]       r_rem, n_rem;
    logic [GainW-1:0]  r_den, n_den;
    logic              r_neg, n_neg;
    logic [CntW-1:0]   r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [31:0]       w_trial;
    logic [32:0]       w_mag;

    always_comb begin
        w_mag = i_num[31] ? 33'(-{i_num[31], i_num}) : {1'b0, i_num};
        w_trial = {r_rem[30:0], r_q[47]};
        n_q = r_q;
        n_rem = r_rem;
        n_den = r_den;
        n_neg = r_neg;
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_q = {w_mag[31:0], 16'd0};
            n_rem = '0;
            n_den = (i_den == '0) ? GainW'(1) : i_den;
            n_neg = i_num[31];
            n_cnt = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                n_rem = w_trial - {1'b0, r_den};
                n_q = {r_q[46:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_q = {r_q[46:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CntW'(47)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
        r_neg <= n_neg;
        r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_ctl = '{start: i_start, busy: r_busy, done: r_done};
    assign o_quot = r_neg ? -$signed({18'd0, r_q}) : $signed({18'd0, r_q});

    ap_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("divider done without work");
    ap_rem_lt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !$past(i_start) |-> r_rem < {1'b0, r_den}) else $error("remainder too large");
endmodule
`default_nettype wire

@@ rtl/first_order_adrc_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none
// First-order linear ADRC. Each item (reference, measured) advances the
// extended state observer by one Euler step and yields one clamped drive
// value. Items are handled one at a time on a bit-serial multiplier and a
// restoring divider: six products, one 48-step division and two error
// terms. A new item is taken in the cycle after the drive value has been
// delivered; any stall on the result channel delays the next item. Gains and
// limits should only be written while no item is in flight.
module first_order_adrc_controller
    import adrc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [RegIdxW-1:0] i_cfg_idx,
    input  wire logic [DataW-1:0]   i_cfg_data,
    adrc_in_if.sink                 in_ch,
    adrc_out_if.source              out_ch
);
    logic [DataW-1:0]        r_h;
    logic [GainW-1:0]        r_b0, r_beta1, r_beta2, r_k1;
    logic signed [DataW-1:0] r_umin, r_umax;
    logic signed [DataW-1:0] r_z1, r_z2, r_last;
    logic signed [DataW-1:0] r_ref, r_meas, r_e, r_d, r_g, r_n, r_drive;
    logic signed [DataW-1:0] n_ref, n_meas, n_e, n_d, n_g, n_n, n_drive;
    logic signed [DataW-1:0] n_z1, n_z2, n_last;
    logic signed [65:0]      r_p1, n_p1;
    t_state                  r_state, n_state;
    logic                    r_go, n_go;

    logic                    w_mstart, w_dstart;
    logic signed [32:0]      w_ma, w_mb;
    t_unit_ctl               w_mctl, w_dctl;
    logic signed [65:0]      w_prod, w_quot;
    logic signed [DataW-1:0] w_sat, w_clamp;

    adrc_mul u_mul (.i_clk, .i_rst_n, .i_start(w_mstart), .i_a(w_ma), .i_b(w_mb),
                    .o_ctl(w_mctl), .o_prod(w_prod));
    adrc_div u_div (.i_clk, .i_rst_n, .i_start(w_dstart), .i_num(r_n), .i_den(r_b0),
                    .o_ctl(w_dctl), .o_quot(w_quot));

    // A unit is started in the first cycle of the state that waits for it.
    assign w_mstart = r_go && (r_state != ST_DIV);
    assign w_dstart = r_go && (r_state == ST_DIV);

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            ST_MUL_B1: begin
                w_ma = 33'(r_e);
                w_mb = {2'b0, r_beta1};
            end
            ST_MUL_B0: begin
                w_ma = 33'(r_last);
                w_mb = {2'b0, r_b0};
            end
            ST_MUL_B2: begin
                w_ma = 33'(r_e);
                w_mb = {2'b0, r_beta2};
            end
            ST_MUL_H1: begin
                w_ma = 33'(r_d);
                w_mb = {1'b0, r_h};
            end
            ST_MUL_H2: begin
                w_ma = 33'(r_g);
                w_mb = {1'b0, r_h};
            end
            ST_MUL_K1: begin
                w_ma = 33'(r_e);
                w_mb = {2'b0, r_k1};
            end
            default: ;
        endcase
    end

    // The lower limit is applied first, so crossed limits leave the upper one.
    always_comb begin
        w_sat = sat32(w_quot);
        w_clamp = w_sat;
        if (w_sat < r_umin) w_clamp = r_umin;
        if (w_clamp > r_umax) w_clamp = r_umax;
    end

    always_comb begin
        n_state = r_state;
        n_go = 1'b0;
        n_ref = r_ref;
        n_meas = r_meas;
        n_e = r_e;
        n_d = r_d;
        n_g = r_g;
        n_n = r_n;
        n_p1 = r_p1;
        n_z1 = r_z1;
        n_z2 = r_z2;
        n_last = r_last;
        n_drive = r_drive;
        case (r_state)
            ST_IDLE: begin
                if (in_ch.valid) begin
                    n_ref = in_ch.reference;
                    n_meas = in_ch.measured;
                    n_state = ST_ERR;
                end
            end
            ST_ERR: begin
                n_e = sat32(66'(r_z1) - 66'(r_meas));
                n_go = 1'b1;
                n_state = ST_MUL_B1;
            end
            ST_MUL_B1: begin
                if (w_mctl.done) begin
                    n_p1 = w_prod >>> 16;
                    n_go = 1'b1;
                    n_state = ST_MUL_B0;
                end
            end
            ST_MUL_B0: begin
                // The observer input is saturated once, over the whole sum.
                if (w_mctl.done) begin
                    n_d = sat32(66'(r_z2) - r_p1 + (w_prod >>> 16));
                    n_go = 1'b1;
                    n_state = ST_MUL_B2;
                end
            end
            ST_MUL_B2: begin
                if (w_mctl.done) begin
                    n_g = sat32(-(w_prod >>> 16));
                    n_go = 1'b1;
                    n_state = ST_MUL_H1;
                end
            end
            ST_MUL_H1: begin
                if (w_mctl.done) begin
                    n_z1 = sat32(66'(r_z1) + (w_prod >>> 32));
                    n_go = 1'b1;
                    n_state = ST_MUL_H2;
                end
            end
            ST_MUL_H2: begin
                if (w_mctl.done) begin
                    n_z2 = sat32(66'(r_z2) + (w_prod >>> 32));
                    n_state = ST_ERR2;
                end
            end
            ST_ERR2: begin
                n_e = sat32(66'(r_ref) - 66'(r_z1));
                n_go = 1'b1;
                n_state = ST_MUL_K1;
            end
            ST_MUL_K1: begin
                if (w_mctl.done) begin
                    n_n = sat32((w_prod >>> 16) - 66'(r_z2));
                    n_go = 1'b1;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_dctl.done) begin
                    n_drive = w_clamp;
                    n_last = w_clamp;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_ch.ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_go <= 1'b0;
            r_h <= 32'd4294967;
            r_b0 <= 31'd65536;
            r_beta1 <= 31'd13107200;
            r_beta2 <= 31'd873791488;
            r_k1 <= 31'd655360;
            r_umin <= 32'sh80000000;
            r_umax <= 32'sh7fffffff;
            r_z1 <= '0;
            r_z2 <= '0;
            r_last <= '0;
        end else begin
            r_state <= n_state;
            r_go <= n_go;
            r_z1 <= n_z1;
            r_z2 <= n_z2;
            r_last <= n_last;
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_STEP_SIZE:  r_h <= i_cfg_data;
                    REG_PLANT_GAIN: r_b0 <= i_cfg_data[GainW-1:0];
                    REG_BETA_ONE:   r_beta1 <= i_cfg_data[GainW-1:0];
                    REG_BETA_TWO:   r_beta2 <= i_cfg_data[GainW-1:0];
                    REG_K_ONE:      r_k1 <= i_cfg_data[GainW-1:0];
                    REG_DRIVE_MIN:  r_umin <= i_cfg_data;
                    REG_DRIVE_MAX:  r_umax <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ref <= n_ref;
        r_meas <= n_meas;
        r_e <= n_e;
        r_d <= n_d;
        r_g <= n_g;
        r_n <= n_n;
        r_p1 <= n_p1;
        r_drive <= n_drive;
    end

    assign in_ch.ready = (r_state == ST_IDLE);
    assign out_ch.valid = (r_state == ST_OUT);
    assign out_ch.drive = r_drive;

    logic unused;
    assign unused = ^{w_dctl.busy, w_mctl.busy, w_mctl.start, w_dctl.start};

    ap_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_ch.ready && out_ch.valid)) else $error("input taken while result pending");
    ap_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.drive))
        else $error("drive changed while waiting");
    ap_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ch.valid && in_ch.ready |=> r_state == ST_ERR) else $error("item not started");
    ap_mul_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mstart |-> !w_mctl.busy) else $error("multiplier started while busy");
endmodule
`default_nettype wire
